@@ design/masked_byte_signature_scanner_macros.svh @@
// Assertion macros for the masked byte signature scanner.
// No dependencies; included by the top level, which does the asserting.
`ifndef MASKED_BYTE_SIGNATURE_SCANNER_MACROS_SVH
`define MASKED_BYTE_SIGNATURE_SCANNER_MACROS_SVH

`ifndef SYNTH
// Plain property, checked at every rising clock edge outside reset.
`define MBSS_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Condition this cycle implies expression next cycle.
`define MBSS_ASSERT_NEXT(name, clk, rst, cond, expr, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) else $error(msg);
`else
`define MBSS_ASSERT(name, clk, rst, prop, msg)
`define MBSS_ASSERT_NEXT(name, clk, rst, cond, expr, msg)
`endif

`endif

@@ design/mbss_pkg.sv @@
// Shared types, command codes and default sizes for the signature scanner.
// No dependencies; imported by the interfaces, the design modules and the testbench.
package mbss_pkg;

   localparam int DEF_NUM_SIGNATURES = 4;
   localparam int DEF_MAX_SIG_LEN    = 32;
   localparam int ADDR_W             = 48;

   // Command codes; code 3 is unused and does nothing
   localparam logic [1:0] CMD_SCAN     = 2'd0;
   localparam logic [1:0] CMD_SIG_BYTE = 2'd1;
   localparam logic [1:0] CMD_SIG_LEN  = 2'd2;

   typedef struct packed {
      logic [1:0]        cmd;
      logic [7:0]        data_byte;
      logic              care;
      logic [1:0]        pattern_index;
      logic [4:0]        byte_position;
      logic [5:0]        pattern_length;
      logic              region_start;
      logic [ADDR_W-1:0] byte_address;
   } req_word_type;

   typedef struct packed {
      logic [1:0]        match_pattern;
      logic [ADDR_W-1:0] match_address;
      logic [5:0]        match_length;
      logic              last;
   } rsp_word_type;

   // Signature table write request
   typedef struct packed {
      logic       byte_en;
      logic       len_en;
      logic [1:0] slot;
      logic [4:0] pos;
      logic [7:0] data;
      logic       care;
      logic [5:0] plen;
   } sig_wr_type;

   // History window control
   typedef struct packed {
      logic shift;
      logic region_start;
   } hist_ctl_type;

   // Hit queue status
   typedef struct packed {
      logic busy;
      logic free;
   } hq_status_type;

endpackage

@@ design/mbss_if.sv @@
// Valid/ready channel interfaces for scan requests and hit responses.
// Depends on mbss_pkg for the word types.
interface mbss_req_if;
   import mbss_pkg::*;
   logic         valid;
   logic         ready;
   req_word_type word;
   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);
endinterface

interface mbss_rsp_if;
   import mbss_pkg::*;
   logic         valid;
   logic         ready;
   rsp_word_type word;
   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);
endinterface

@@ design/masked_byte_signature_scanner.sv @@
// A word is held in the input register, and its hits pass on to the result register,
//   which offers them one hit per cycle while the sink is ready.
// Throughput: one request word per cycle, unless a byte with hits waits in the input
//   register while the result register still holds an earlier byte's untaken hits.
// Reset (synchronous, active high) disables all slots, clears the region count and
//   empties both registers; table bytes and history hold. Needs mbss_pkg, mbss_if.
`include "masked_byte_signature_scanner_macros.svh"

module masked_byte_signature_scanner #(
   parameter int NUM_SIGNATURES = mbss_pkg::DEF_NUM_SIGNATURES,
   parameter int MAX_SIG_LEN    = mbss_pkg::DEF_MAX_SIG_LEN
) (
   input  logic       clock,
   input  logic       reset,
   mbss_req_if.sink   req_chan,
   mbss_rsp_if.source rsp_chan
);
   import mbss_pkg::*;

   localparam int LEN_W = $clog2(MAX_SIG_LEN + 1);

   // Input register: the word under work this cycle
   logic         a_valid_ff;
   req_word_type a_word_ff;
   logic         a_go;

   // Decoded command of the word in the input register
   logic is_scan;
   logic is_byte_wr;
   logic is_len_wr;

   sig_wr_type    sig_wr;
   hist_ctl_type  hist_ctl;
   hq_status_type hq_stat;
   logic          hq_load;

   logic [7:0]                sig_bytes [NUM_SIGNATURES][MAX_SIG_LEN];
   logic                      sig_care  [NUM_SIGNATURES][MAX_SIG_LEN];
   logic [LEN_W-1:0]          sig_len   [NUM_SIGNATURES];
   logic [7:0]                hist      [MAX_SIG_LEN-1];
   logic [LEN_W-1:0]          seen_now;
   logic [NUM_SIGNATURES-1:0] hit_mask;

   always_comb begin
      is_scan    = 1'b0;
      is_byte_wr = 1'b0;
      is_len_wr  = 1'b0;
      case (a_word_ff.cmd)
         CMD_SCAN:     is_scan    = a_valid_ff;
         CMD_SIG_BYTE: is_byte_wr = a_valid_ff;
         CMD_SIG_LEN:  is_len_wr  = a_valid_ff;
         default: begin
            // unused command: retires with no effect
         end
      endcase
   end

   // The word leaves the input register when its hits (if any) can go into
   // the result register. Table writes and history shifts happen on that
   // same edge, so a later byte always sees them and this byte does not.
   assign a_go           = a_valid_ff && (hq_stat.free || (hit_mask == '0));
   assign req_chan.ready = !a_valid_ff || a_go;
   assign hq_load        = a_go && (hit_mask != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (req_chan.valid && req_chan.ready) begin
         a_valid_ff <= 1'b1;
      end else if (a_go) begin
         a_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         a_word_ff <= req_chan.word;
      end
   end

   assign sig_wr.byte_en = a_go && is_byte_wr;
   assign sig_wr.len_en  = a_go && is_len_wr;
   assign sig_wr.slot    = a_word_ff.pattern_index;
   assign sig_wr.pos     = a_word_ff.byte_position;
   assign sig_wr.data    = a_word_ff.data_byte;
   assign sig_wr.care    = a_word_ff.care;
   assign sig_wr.plen    = a_word_ff.pattern_length;

   assign hist_ctl.shift        = a_go && is_scan;
   assign hist_ctl.region_start = a_word_ff.region_start;

   mbss_sig_table #(
      .NUM_SIGNATURES (NUM_SIGNATURES),
      .MAX_SIG_LEN    (MAX_SIG_LEN),
      .LEN_W          (LEN_W)
   ) u_sig_table (
      .clock     (clock),
      .reset     (reset),
      .wr        (sig_wr),
      .sig_bytes (sig_bytes),
      .sig_care  (sig_care),
      .sig_len   (sig_len)
   );

   mbss_history #(
      .MAX_SIG_LEN (MAX_SIG_LEN),
      .LEN_W       (LEN_W)
   ) u_history (
      .clock    (clock),
      .reset    (reset),
      .ctl      (hist_ctl),
      .cur_byte (a_word_ff.data_byte),
      .hist     (hist),
      .seen_now (seen_now)
   );

   // Region gating: a slot is only tested once the region holds at least
   // its length, so stale history from an earlier region is never used.
   mbss_match #(
      .NUM_SIGNATURES (NUM_SIGNATURES),
      .MAX_SIG_LEN    (MAX_SIG_LEN),
      .LEN_W          (LEN_W)
   ) u_match (
      .is_scan   (is_scan),
      .cur_byte  (a_word_ff.data_byte),
      .hist      (hist),
      .seen      (seen_now),
      .sig_bytes (sig_bytes),
      .sig_care  (sig_care),
      .sig_len   (sig_len),
      .hit_mask  (hit_mask)
   );

   // Lengths are captured with the hits, since later length writes may
   // retire while these hits still wait.
   mbss_hit_queue #(
      .NUM_SIGNATURES (NUM_SIGNATURES),
      .MAX_SIG_LEN    (MAX_SIG_LEN),
      .LEN_W          (LEN_W)
   ) u_hit_queue (
      .clock     (clock),
      .reset     (reset),
      .load      (hq_load),
      .load_mask (hit_mask),
      .load_addr (a_word_ff.byte_address),
      .load_lens (sig_len),
      .status    (hq_stat),
      .rsp_chan  (rsp_chan)
   );

   // Checks
   `MBSS_ASSERT(a_empty_ready, clock, reset, !a_valid_ff |-> req_chan.ready,
                "empty input stage not ready")
   `MBSS_ASSERT(a_load_free, clock, reset, hq_load |-> hq_stat.free,
                "hits loaded over pending hits")
   `MBSS_ASSERT_NEXT(a_stall_hold, clock, reset,
                     rsp_chan.valid && !rsp_chan.ready && a_valid_ff && (hit_mask != '0),
                     a_valid_ff && $stable(a_word_ff),
                     "word with hits left input stage during stall")
   `MBSS_ASSERT_NEXT(a_reset_quiet, clock, 1'b0, reset, !rsp_chan.valid && !a_valid_ff,
                     "pipeline not empty after reset")

endmodule

@@ design/mbss_sig_table.sv @@
// Signature table: bytes, care bits and lengths for every slot.
// Depends on mbss_pkg.
module mbss_sig_table #(
   parameter int NUM_SIGNATURES = mbss_pkg::DEF_NUM_SIGNATURES,
   parameter int MAX_SIG_LEN    = mbss_pkg::DEF_MAX_SIG_LEN,
   parameter int LEN_W          = $clog2(MAX_SIG_LEN + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  mbss_pkg::sig_wr_type wr,
   output logic [7:0]         sig_bytes [NUM_SIGNATURES][MAX_SIG_LEN],
   output logic               sig_care  [NUM_SIGNATURES][MAX_SIG_LEN],
   output logic [LEN_W-1:0]   sig_len   [NUM_SIGNATURES]
);
   import mbss_pkg::*;

   localparam int SLOT_W = (NUM_SIGNATURES > 1) ? $clog2(NUM_SIGNATURES) : 1;
   localparam int POS_W  = $clog2(MAX_SIG_LEN);

   logic [7:0]       bytes_ff [NUM_SIGNATURES][MAX_SIG_LEN];
   logic             care_ff  [NUM_SIGNATURES][MAX_SIG_LEN];
   logic [LEN_W-1:0] len_ff   [NUM_SIGNATURES];
   logic [LEN_W-1:0] len_in;
   logic [SLOT_W-1:0] wr_slot;
   logic [POS_W-1:0]  wr_pos;
   logic              slot_ok;
   logic              pos_ok;

   assign wr_slot = SLOT_W'(wr.slot);
   assign wr_pos  = POS_W'(wr.pos);
   assign slot_ok = int'(wr.slot) < NUM_SIGNATURES;
   assign pos_ok  = int'(wr.pos) < MAX_SIG_LEN;
   // oversized lengths saturate
   assign len_in  = (int'(wr.plen) > MAX_SIG_LEN) ? LEN_W'(MAX_SIG_LEN) : LEN_W'(wr.plen);

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '{default: '0};
      end else if (wr.len_en && slot_ok) begin
         len_ff[wr_slot] <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.byte_en && slot_ok && pos_ok) begin
         bytes_ff[wr_slot][wr_pos] <= wr.data;
         care_ff[wr_slot][wr_pos]  <= wr.care;
      end
   end

   assign sig_bytes = bytes_ff;
   assign sig_care  = care_ff;
   assign sig_len   = len_ff;

endmodule

@@ design/mbss_history.sv @@
// History shift line of past scanned bytes and the region byte count.
// Depends on mbss_pkg.
module mbss_history #(
   parameter int MAX_SIG_LEN = mbss_pkg::DEF_MAX_SIG_LEN,
   parameter int LEN_W       = $clog2(MAX_SIG_LEN + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  mbss_pkg::hist_ctl_type ctl,
   input  logic [7:0]             cur_byte,
   output logic [7:0]             hist [MAX_SIG_LEN-1],
   output logic [LEN_W-1:0]       seen_now
);
   import mbss_pkg::*;

   logic [7:0]       hist_ff [MAX_SIG_LEN-1];
   logic [LEN_W-1:0] seen_ff;

   // count including the byte now being scanned, saturating
   always_comb begin
      if (ctl.region_start) begin
         seen_now = LEN_W'(1);
      end else if (int'(seen_ff) < MAX_SIG_LEN) begin
         seen_now = seen_ff + LEN_W'(1);
      end else begin
         seen_now = seen_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
      end else if (ctl.shift) begin
         seen_ff <= seen_now;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.shift) begin
         hist_ff[0] <= cur_byte;
         for (int i = 1; i < MAX_SIG_LEN - 1; i++) begin
            hist_ff[i] <= hist_ff[i-1];
         end
      end
   end

   assign hist = hist_ff;

endmodule

@@ design/mbss_match.sv @@
// Parallel masked comparators of every slot against the window.
// Depends on mbss_pkg.
module mbss_match #(
   parameter int NUM_SIGNATURES = mbss_pkg::DEF_NUM_SIGNATURES,
   parameter int MAX_SIG_LEN    = mbss_pkg::DEF_MAX_SIG_LEN,
   parameter int LEN_W          = $clog2(MAX_SIG_LEN + 1)
) (
   input  logic                      is_scan,
   input  logic [7:0]                cur_byte,
   input  logic [7:0]                hist      [MAX_SIG_LEN-1],
   input  logic [LEN_W-1:0]          seen,
   input  logic [7:0]                sig_bytes [NUM_SIGNATURES][MAX_SIG_LEN],
   input  logic                      sig_care  [NUM_SIGNATURES][MAX_SIG_LEN],
   input  logic [LEN_W-1:0]          sig_len   [NUM_SIGNATURES],
   output logic [NUM_SIGNATURES-1:0] hit_mask
);
   import mbss_pkg::*;

   localparam int POS_W = $clog2(MAX_SIG_LEN);

   logic [7:0]             win     [MAX_SIG_LEN];
   logic [MAX_SIG_LEN-1:0] cand    [NUM_SIGNATURES];
   logic [LEN_W-1:0]       len_m1  [NUM_SIGNATURES];

   // win[a] is the byte a positions back; win[0] is the current byte
   always_comb begin
      win[0] = cur_byte;
      for (int a = 1; a < MAX_SIG_LEN; a++) begin
         win[a] = hist[a-1];
      end
   end

   // cand[s][d]: signature bytes 0..d line up with the window of d+1 bytes,
   // i.e. a hit for slot s if its length is d+1
   always_comb begin
      for (int s = 0; s < NUM_SIGNATURES; s++) begin
         for (int d = 0; d < MAX_SIG_LEN; d++) begin
            cand[s][d] = 1'b1;
            for (int j = 0; j <= d; j++) begin
               if (sig_care[s][j] && (sig_bytes[s][j] != win[d-j])) begin
                  cand[s][d] = 1'b0;
               end
            end
         end
      end
   end

   always_comb begin
      for (int s = 0; s < NUM_SIGNATURES; s++) begin
         len_m1[s]   = sig_len[s] - LEN_W'(1);
         hit_mask[s] = is_scan && (sig_len[s] != '0) && (sig_len[s] <= seen) &&
                       cand[s][len_m1[s][POS_W-1:0]];
      end
   end

endmodule

@@ design/mbss_hit_queue.sv @@
// Result register: holds one byte's hits and emits them lowest slot first.
// Depends on mbss_pkg and mbss_rsp_if.
module mbss_hit_queue #(
   parameter int NUM_SIGNATURES = mbss_pkg::DEF_NUM_SIGNATURES,
   parameter int MAX_SIG_LEN    = mbss_pkg::DEF_MAX_SIG_LEN,
   parameter int LEN_W          = $clog2(MAX_SIG_LEN + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  logic [NUM_SIGNATURES-1:0]     load_mask,
   input  logic [mbss_pkg::ADDR_W-1:0]   load_addr,
   input  logic [LEN_W-1:0]              load_lens [NUM_SIGNATURES],
   output mbss_pkg::hq_status_type       status,
   mbss_rsp_if.source                    rsp_chan
);
   import mbss_pkg::*;

   localparam int SLOT_W = (NUM_SIGNATURES > 1) ? $clog2(NUM_SIGNATURES) : 1;

   logic [NUM_SIGNATURES-1:0] mask_ff;
   logic [NUM_SIGNATURES-1:0] mask_in;
   logic [NUM_SIGNATURES-1:0] low_bit;
   logic [ADDR_W-1:0]         addr_ff;
   logic [LEN_W-1:0]          lens_ff [NUM_SIGNATURES];
   logic [SLOT_W-1:0]         sel;
   logic [LEN_W-1:0]          sel_len;
   logic                      last;
   logic                      take;

   // isolate lowest pending hit
   assign low_bit = mask_ff & (~mask_ff + NUM_SIGNATURES'(1));

   always_comb begin
      sel     = '0;
      sel_len = '0;
      for (int s = 0; s < NUM_SIGNATURES; s++) begin
         if (low_bit[s]) begin
            sel     = sel | SLOT_W'(s);
            sel_len = sel_len | lens_ff[s];
         end
      end
   end

   assign last = (mask_ff & ~low_bit) == '0;
   assign take = rsp_chan.valid && rsp_chan.ready;

   assign rsp_chan.valid              = |mask_ff;
   assign rsp_chan.word.match_pattern = 2'(sel);
   assign rsp_chan.word.match_address = addr_ff - ADDR_W'(sel_len - LEN_W'(1));
   assign rsp_chan.word.match_length  = 6'(sel_len);
   assign rsp_chan.word.last          = last;

   assign status.busy = |mask_ff;
   assign status.free = !rsp_chan.valid || (take && last);

   always_comb begin
      if (load) begin
         mask_in = load_mask;
      end else if (take) begin
         mask_in = mask_ff & ~low_bit;
      end else begin
         mask_in = mask_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else begin
         mask_ff <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         addr_ff <= load_addr;
         lens_ff <= load_lens;
      end
   end

endmodule

@@ sim/masked_byte_signature_scanner_tb.sv @@
// Self-checking testbench for the masked byte signature scanner.
// Depends on mbss_pkg, the mbss_req_if/mbss_rsp_if channels and the design under test.
`timescale 1ns / 1ps

module masked_byte_signature_scanner_tb;
   import mbss_pkg::*;

   localparam int NUM_SIG = DEF_NUM_SIGNATURES;
   localparam int SIG_MAX = DEF_MAX_SIG_LEN;

   // Code 3 has no function; the block must swallow it silently
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   // Cycles with no word moving on either channel before the run is declared hung.
   localparam int WATCHDOG_LIMIT = 1000;
   // Quiet cycles after the last hit before the final verdict
   localparam int TAIL_CYCLES    = 16;
   // Random words to send before the random phase stops
   localparam int RANDOM_WORDS   = 100;
   // Table depth written for all but the last slot; their lengths stay within it
   localparam int SHORT_MAX      = 8;

   logic clock;
   logic reset;

   mbss_req_if req_if ();
   mbss_rsp_if rsp_if ();

   masked_byte_signature_scanner u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // ---------------------------------------------------------------------
   // Scanner shadow: signature table, region count and byte history
   // ---------------------------------------------------------------------
   logic [7:0] sig_byte_m [NUM_SIG][SIG_MAX];
   logic       sig_care_m [NUM_SIG][SIG_MAX];
   logic [5:0] sig_len_m  [NUM_SIG];
   logic [7:0] history_m  [SIG_MAX-1];
   int         region_count;

   rsp_word_type step_hits [$];   // hits caused by the word just accepted
   rsp_word_type hits_due  [$];   // hits still owed by the block, oldest first

   // Typed-in expectation that travels with the word being offered
   bit           word_typed;
   bit           word_hit_on;
   rsp_word_type word_hit;

   bit           steady;          // no random idling on either side while set
   int           mismatches;
   int           stall_cycles;

   // Apply one accepted word to the shadow and collect the hits it causes.
   // Config words only touch the table; a scan compares every enabled slot whose length
   // fits in the region against the window that ends at this byte, oldest byte at position 0.
   function automatic void compute_hits(input req_word_type w);
      int unsigned  len;
      int unsigned  age;
      bit           ok;
      logic [7:0]   b;
      rsp_word_type h;
      step_hits.delete();
      case (w.cmd)
         CMD_SIG_BYTE: begin
            sig_byte_m[w.pattern_index][w.byte_position] = w.data_byte;
            sig_care_m[w.pattern_index][w.byte_position] = w.care;
         end
         CMD_SIG_LEN: begin
            // lengths past the table depth clamp to the full depth
            sig_len_m[w.pattern_index] = (w.pattern_length > SIG_MAX) ?
                                         6'(SIG_MAX) : w.pattern_length;
         end
         CMD_SCAN: begin
            if (w.region_start)
               region_count = 0;
            if (region_count < SIG_MAX)
               region_count++;
            for (int s = 0; s < NUM_SIG; s++) begin
               len = sig_len_m[s];
               // short region or disabled slot: no compare at all
               if (len != 0 && len <= region_count) begin
                  ok = 1'b1;
                  for (int j = 0; j < len; j++) begin
                     age = len - 1 - j;
                     b   = (age == 0) ? w.data_byte : history_m[age-1];
                     if (sig_care_m[s][j] && sig_byte_m[s][j] != b)
                        ok = 1'b0;
                  end
                  if (ok) begin
                     h.match_pattern = 2'(s);
                     h.match_address = w.byte_address - ADDR_W'(len - 1);
                     h.match_length  = 6'(len);
                     h.last          = 1'b0;
                     step_hits = {step_hits, h};
                  end
               end
            end
            if (step_hits.size() != 0)
               step_hits[step_hits.size()-1].last = 1'b1;
            for (int k = SIG_MAX - 2; k > 0; k--)
               history_m[k] = history_m[k-1];
            history_m[0] = w.data_byte;
         end
         default: ;
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Word builders
   // ---------------------------------------------------------------------
   // Every field random; callers overwrite the fields their command uses
   function automatic req_word_type noise_word();
      logic [95:0] r;
      r = {$urandom, $urandom, $urandom};
      return r[$bits(req_word_type)-1:0];
   endfunction

   function automatic req_word_type scan_word(input bit rs, input logic [ADDR_W-1:0] addr,
                                              input logic [7:0] data);
      req_word_type w;
      w              = '0;
      w.cmd          = CMD_SCAN;
      w.region_start = rs;
      w.byte_address = addr;
      w.data_byte    = data;
      return w;
   endfunction

   function automatic req_word_type sig_byte_word(input int slot, input int pos,
                                                  input logic [7:0] data, input bit care);
      req_word_type w;
      w               = '0;
      w.cmd           = CMD_SIG_BYTE;
      w.pattern_index = 2'(slot);
      w.byte_position = 5'(pos);
      w.data_byte     = data;
      w.care          = care;
      return w;
   endfunction

   function automatic req_word_type sig_len_word(input int slot, input int len);
      req_word_type w;
      w                = '0;
      w.cmd            = CMD_SIG_LEN;
      w.pattern_index  = 2'(slot);
      w.pattern_length = 6'(len);
      return w;
   endfunction

   function automatic rsp_word_type sole_hit(input int pat, input logic [ADDR_W-1:0] addr,
                                             input int len);
      rsp_word_type h;
      h.match_pattern = 2'(pat);
      h.match_address = addr;
      h.match_length  = 6'(len);
      h.last          = 1'b1;
      return h;
   endfunction

   // Mostly short signatures; the full depth and oversize lengths now and then
   function automatic int pick_len();
      int r;
      r = $urandom_range(19);
      if (r == 0)       return 0;
      else if (r <= 12) return $urandom_range(6, 1);
      else if (r <= 14) return SIG_MAX;
      else if (r <= 16) return $urandom_range(63, SIG_MAX + 1);
      else              return $urandom_range(SIG_MAX - 1, 7);
   endfunction

   // Region base: zero, just below the address wrap, or anywhere
   function automatic logic [ADDR_W-1:0] region_base();
      logic [63:0] r;
      int          pick;
      r    = {$urandom, $urandom};
      pick = $urandom_range(9);
      if (pick == 0)
         return '0;
      else if (pick == 1)
         return {ADDR_W{1'b1}} - ADDR_W'($urandom_range(40));
      return r[ADDR_W-1:0];
   endfunction

   // ---------------------------------------------------------------------
   // Clock, reset-time values, sink stalls
   // ---------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      reset        = 1'b1;
      req_if.valid = 1'b0;
      req_if.word  = '0;
      rsp_if.ready = 1'b0;
      word_typed   = 1'b0;
      word_hit_on  = 1'b0;
      word_hit     = '0;
      steady       = 1'b0;
   end

   // Sink holds off at random with a chance of 8 in 100, except in the steady stretch
   always @(negedge clock)
      rsp_if.ready <= steady || ($urandom_range(99) >= 8);

   // ---------------------------------------------------------------------
   // Monitor: predict on every accepted request word, check every hit
   // ---------------------------------------------------------------------
   function automatic void note_mismatch(input string what, input rsp_word_type e,
                                         input rsp_word_type g);
      mismatches++;
      if (mismatches <= 10)
         $display({"%0t hit %s: exp pat %0d addr %h len %0d last %0b,",
                   " got pat %0d addr %h len %0d last %0b"},
                  $realtime, what, e.match_pattern, e.match_address, e.match_length, e.last,
                  g.match_pattern, g.match_address, g.match_length, g.last);
   endfunction

   initial begin
      region_count = 0;
      mismatches   = 0;
      stall_cycles = 0;
      foreach (sig_len_m[s])
         sig_len_m[s] = '0;
      foreach (history_m[k])
         history_m[k] = '0;
      foreach (sig_byte_m[s, p]) begin
         sig_byte_m[s][p] = '0;
         sig_care_m[s][p] = 1'b0;
      end
   end

   always @(posedge clock) begin
      rsp_word_type e;
      bit           moved;
      if (!reset) begin
         moved = 1'b0;
         if (req_if.valid === 1'b1 && req_if.ready === 1'b1) begin
            moved = 1'b1;
            compute_hits(req_if.word);
            // typed-in rows replace the shadow's answer for that word
            if (word_typed) begin
               if (word_hit_on)
                  hits_due = {hits_due, word_hit};
            end else begin
               foreach (step_hits[i])
                  hits_due = {hits_due, step_hits[i]};
            end
         end
         if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            moved = 1'b1;
            if (hits_due.size() == 0) begin
               note_mismatch("unexpected", '0, rsp_if.word);
            end else begin
               e = hits_due.pop_front();
               if (rsp_if.word.match_pattern !== e.match_pattern ||
                   rsp_if.word.match_address !== e.match_address ||
                   rsp_if.word.match_length  !== e.match_length  ||
                   rsp_if.word.last          !== e.last)
                  note_mismatch("mismatch", e, rsp_if.word);
            end
         end
         stall_cycles = moved ? 0 : stall_cycles + 1;
      end
   end

   // Watchdog: a hung handshake ends the run
   initial begin
      do @(negedge clock); while (stall_cycles < WATCHDOG_LIMIT);
      $display("masked_byte_signature_scanner: mismatch");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Source side
   // ---------------------------------------------------------------------
   // Offer one word, starting and ending at a falling edge. Random idle
   // cycles go in front; valid stays high until the word is taken.
   task automatic send_word(input req_word_type w, input bit typed, input bit hit_on,
                            input rsp_word_type hit);
      if (!steady)
         while ($urandom_range(99) < 8) begin
            req_if.valid <= 1'b0;
            @(negedge clock);
         end
      req_if.valid <= 1'b1;
      req_if.word  <= w;
      word_typed   <= typed;
      word_hit_on  <= hit_on;
      word_hit     <= hit;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      @(negedge clock);
   endtask

   // Hold the source off until every owed hit has come back
   task automatic drain();
      req_if.valid <= 1'b0;
      do @(negedge clock); while (hits_due.size() != 0);
   endtask

   typedef struct {
      req_word_type w;
      bit           typed;
      bit           hit_on;
      rsp_word_type hit;
   } stim_row_type;

   stim_row_type directed_rows [$];

   function automatic void add_row(input req_word_type w, input bit typed, input bit hit_on,
                                   input rsp_word_type hit);
      stim_row_type r;
      r.w      = w;
      r.typed  = typed;
      r.hit_on = hit_on;
      r.hit    = hit;
      directed_rows = {directed_rows, r};
   endfunction

   logic [ADDR_W-1:0] next_addr;
   int                rand_words;

   // One random scan byte; addresses run on within a region
   task automatic scan_byte(input bit rs, input logic [7:0] d);
      req_word_type w;
      w = noise_word();
      if (rs)
         next_addr = region_base();
      w.cmd          = CMD_SCAN;
      w.region_start = rs;
      w.data_byte    = d;
      w.byte_address = next_addr;
      next_addr++;
      send_word(w, 1'b0, 1'b0, '0);
      rand_words++;
   endtask

   localparam logic [ADDR_W-1:0] ADDR_TOP = {ADDR_W{1'b1}};

   initial begin
      req_word_type w;
      int           pick;
      int           slot;
      int           len;
      int           lead;
      int           burst;
      int           last_drain;
      bit           rs;
      logic [7:0]   d;

      next_addr  = '0;
      rand_words = 0;
      last_drain = 0;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Table entries written once, all wildcards, so no compare ever reads
      // an entry that was never written: the first SHORT_MAX bytes of each
      // slot, and the last slot over its full depth
      for (int s = 0; s < NUM_SIG; s++)
         for (int p = 0; p < ((s == NUM_SIG - 1) ? SIG_MAX : SHORT_MAX); p++)
            send_word(sig_byte_word(s, p, 8'($urandom), 1'b0), 1'b0, 1'b0, '0);

      // Directed rows; typed-in expectations where the answer is obvious
      add_row(scan_word(1'b1, '0, 8'h00), 1'b1, 1'b0, '0);         // all slots off
      add_row(sig_len_word(0, 1), 1'b1, 1'b0, '0);
      add_row(scan_word(1'b1, ADDR_TOP, 8'hFF), 1'b1, 1'b1, sole_hit(0, ADDR_TOP, 1));
      add_row(sig_byte_word(0, 0, 8'hA5, 1'b1), 1'b1, 1'b0, '0);
      add_row(scan_word(1'b0, 48'd1, 8'h5A), 1'b1, 1'b0, '0);      // cared byte differs
      add_row(scan_word(1'b0, 48'd2, 8'hA5), 1'b1, 1'b1, sole_hit(0, 48'd2, 1));
      add_row(sig_len_word(3, 63), 1'b1, 1'b0, '0);                // clamps to full depth
      w     = '0;
      w.cmd = CMD_UNUSED;
      add_row(w, 1'b1, 1'b0, '0);
      add_row(sig_len_word(3, 0), 1'b1, 1'b0, '0);                 // slot off again
      add_row(sig_len_word(1, 2), 1'b1, 1'b0, '0);
      add_row(scan_word(1'b1, '0, 8'h33), 1'b1, 1'b0, '0);         // region too short
      add_row(scan_word(1'b0, 48'd1, 8'hA5), 1'b0, 1'b0, '0);      // two hits, in slot order
      add_row(scan_word(1'b1, 48'd10, 8'h44), 1'b1, 1'b0, '0);     // old bytes not used
      add_row(scan_word(1'b1, ADDR_TOP, 8'h00), 1'b1, 1'b0, '0);
      add_row(scan_word(1'b0, '0, 8'h00), 1'b1, 1'b1, sole_hit(1, ADDR_TOP, 2)); // wraps
      add_row(sig_byte_word(1, 1, 8'hFF, 1'b1), 1'b1, 1'b0, '0);
      add_row(scan_word(1'b0, 48'd1, 8'hFF), 1'b1, 1'b1, sole_hit(1, '0, 2));
      add_row(scan_word(1'b0, 48'd2, 8'hFE), 1'b1, 1'b0, '0);
      add_row(sig_byte_word(3, SIG_MAX - 1, 8'hFF, 1'b1), 1'b0, 1'b0, '0);
      add_row(sig_len_word(3, SIG_MAX + 1), 1'b0, 1'b0, '0);       // clamps to full depth
      add_row(sig_byte_word(0, 0, 8'h00, 1'b0), 1'b0, 1'b0, '0);
      add_row(scan_word(1'b1, 48'd5, 8'h77), 1'b0, 1'b0, '0);

      foreach (directed_rows[i])
         send_word(directed_rows[i].w, directed_rows[i].typed, directed_rows[i].hit_on,
                   directed_rows[i].hit);
      drain();

      // Random phase: planted signatures with random wildcard bytes,
      // plus table rewrites, stray scans and dead commands
      while (rand_words < RANDOM_WORDS) begin
         steady <= (rand_words >= 30 && rand_words < 70);
         pick = $urandom_range(99);
         if (pick < 10) begin
            w     = noise_word();
            w.cmd = CMD_SIG_LEN;
            // only the last slot is written deep enough for long signatures
            if (int'(w.pattern_index) == NUM_SIG - 1)
               w.pattern_length = 6'(pick_len());
            else
               w.pattern_length = 6'($urandom_range(SHORT_MAX));
            send_word(w, 1'b0, 1'b0, '0);
            rand_words++;
         end else if (pick < 25) begin
            repeat ($urandom_range(4, 1)) begin
               w     = noise_word();
               w.cmd = CMD_SIG_BYTE;
               send_word(w, 1'b0, 1'b0, '0);
               rand_words++;
            end
         end else if (pick < 30) begin
            w     = noise_word();
            w.cmd = CMD_UNUSED;
            send_word(w, 1'b0, 1'b0, '0);
            rand_words++;
         end else if (pick < 70) begin
            // plant: optional new region, a few lead bytes, then the signature
            slot = $urandom_range(NUM_SIG - 1);
            for (int t = 0; t < NUM_SIG && sig_len_m[slot] == 0; t++)
               slot = (slot + 1) % NUM_SIG;
            len  = sig_len_m[slot];
            rs   = $urandom_range(1);
            lead = $urandom_range(3);
            for (int i = 0; i < lead; i++)
               scan_byte(rs && i == 0, 8'($urandom));
            for (int j = 0; j < len; j++) begin
               if (sig_care_m[slot][j])
                  d = sig_byte_m[slot][j];
               else
                  d = $urandom_range(1) ? 8'($urandom) : 8'($urandom_range(3));
               scan_byte(rs && lead == 0 && j == 0, d);
            end
         end else begin
            burst = $urandom_range(8, 1);
            for (int i = 0; i < burst; i++) begin
               d = $urandom_range(2) == 0 ? 8'($urandom) : 8'($urandom_range(3));
               scan_byte(i == 0 && $urandom_range(4) == 0, d);
            end
         end
         // Periodic full drain so the source sits idle against an empty pipe
         if (rand_words - last_drain >= 40) begin
            last_drain = rand_words;
            drain();
         end
      end

      steady <= 1'b0;
      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && hits_due.size() == 0)
         $display("masked_byte_signature_scanner: match");
      else
         $display("masked_byte_signature_scanner: mismatch");
      $finish;
   end

endmodule
